// ----- hdl/twrtc_pkg.sv -----
package twrtc_pkg;

  localparam int unsigned BURST_BYTES = 7;

  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_SINGLE = 2'd2;
  localparam logic [1:0] CMD_BURST  = 2'd3;

  localparam logic [7:0] BURST_CMD_BYTE = 8'hBF;
  localparam logic [7:0] SEC_MASK       = 8'h7F;
  localparam logic [7:0] HOUR_MASK      = 8'h3F;
  localparam logic [6:0] MAX_DECIMAL    = 7'd99;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] reg_addr;
    logic [6:0] write_value;
    logic       dat_in;
  } req_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       dat_out;
    logic       dat_drive;
    logic       busy_res;
    logic       value_valid;
    logic [7:0] value;
    logic [2:0] value_index;
    logic       value_last;
  } res_t;

  // saturate to 99, then split into tens and units (x*205 >> 11 == x/10 here)
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [6:0]  s;
    logic [17:0] p;
    logic [3:0]  q;
    logic [6:0]  r;
    s = (v > MAX_DECIMAL) ? MAX_DECIMAL : v;
    p = {11'b0, s} * 18'd205;
    q = p[14:11];
    r = s - ({3'b0, q} * 7'd10);
    return {q, r[3:0]};
  endfunction

  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'b0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'b0, b[3:0]};
  endfunction

endpackage

// ----- hdl/twrtc_in_if.sv -----
interface twrtc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] reg_addr;
  logic [6:0] write_value;
  logic       dat_in;

  modport source (output valid, cmd, reg_addr, write_value, dat_in, input ready);
  modport sink   (input valid, cmd, reg_addr, write_value, dat_in, output ready);
endinterface

// ----- hdl/twrtc_out_if.sv -----
interface twrtc_out_if;
  logic       valid;
  logic       ready;
  logic       chip_enable;
  logic       serial_clock;
  logic       dat_out;
  logic       dat_drive;
  logic       busy_res;
  logic       value_valid;
  logic [7:0] value;
  logic [2:0] value_index;
  logic       value_last;

  modport source (output valid, chip_enable, serial_clock, dat_out, dat_drive, busy_res,
                  value_valid, value, value_index, value_last, input ready);
  modport sink   (input valid, chip_enable, serial_clock, dat_out, dat_drive, busy_res,
                  value_valid, value, value_index, value_last, output ready);
endinterface

// ----- hdl/twrtc_seq.sv -----
module twrtc_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  twrtc_pkg::req_t   req,
  input  logic [7:0]        half_period,
  output twrtc_pkg::res_t   res
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_TX_LO = 3'd1;
  localparam logic [2:0] PH_TX_HI = 3'd2;
  localparam logic [2:0] PH_RX_LO = 3'd3;
  localparam logic [2:0] PH_RX_HI = 3'd4;
  localparam logic [2:0] PH_END   = 3'd5;

  localparam logic [3:0] BURST_N = 4'(twrtc_pkg::BURST_BYTES);

  logic [2:0] phase_r, phase_nxt;
  logic [1:0] op_r, op_nxt;
  logic [2:0] bit_cnt_r, bit_cnt_nxt;
  logic [2:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic [7:0] div_r, div_nxt;
  logic       ce_r, ce_nxt;
  logic       sclk_r, sclk_nxt;
  logic       drv_r, drv_nxt;

  logic [7:0] hp;
  logic       half_done;
  logic [7:0] rx_byte;
  logic [3:0] nbytes;
  logic       rx_last;
  logic       vld;
  logic [7:0] val;
  logic [2:0] idx;

  assign hp        = (half_period == 8'd0) ? 8'd1 : half_period;
  assign half_done = ({1'b0, div_r} + 9'd1) >= {1'b0, hp};
  assign nbytes    = (op_r == twrtc_pkg::CMD_BURST) ? BURST_N : 4'd1;
  assign rx_last   = ({1'b0, byte_cnt_r} + 4'd1) >= nbytes;

  always_comb begin
    rx_byte = shift_r | ({7'b0, req.dat_in} << bit_cnt_r);
    if (op_r == twrtc_pkg::CMD_BURST && byte_cnt_r == 3'd0) begin
      rx_byte = rx_byte & twrtc_pkg::SEC_MASK;
    end
    if (op_r == twrtc_pkg::CMD_BURST && byte_cnt_r == 3'd2) begin
      rx_byte = rx_byte & twrtc_pkg::HOUR_MASK;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    op_nxt       = op_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    shift_nxt    = shift_r;
    pend_nxt     = pend_r;
    div_nxt      = div_r;
    ce_nxt       = ce_r;
    sclk_nxt     = sclk_r;
    drv_nxt      = drv_r;
    vld          = 1'b0;
    val          = 8'd0;
    idx          = 3'd0;

    if (phase_r == PH_IDLE || phase_r > PH_END) begin
      phase_nxt = PH_IDLE;
      ce_nxt    = 1'b0;
      sclk_nxt  = 1'b0;
      drv_nxt   = 1'b0;
      if (req.cmd != twrtc_pkg::CMD_NONE) begin
        op_nxt = req.cmd;
        unique case (req.cmd)
          twrtc_pkg::CMD_WRITE:  shift_nxt = req.reg_addr;
          twrtc_pkg::CMD_SINGLE: shift_nxt = req.reg_addr + 8'd1;
          default:               shift_nxt = twrtc_pkg::BURST_CMD_BYTE;
        endcase
        pend_nxt     = twrtc_pkg::to_bcd(req.write_value);
        bit_cnt_nxt  = 3'd0;
        byte_cnt_nxt = 3'd0;
        div_nxt      = 8'd0;
        phase_nxt    = PH_TX_LO;
        ce_nxt       = 1'b1;
        drv_nxt      = 1'b1;
      end
    end else if (!half_done) begin
      div_nxt = div_r + 8'd1;
    end else begin
      div_nxt = 8'd0;
      unique case (phase_r)
        PH_TX_LO: begin
          phase_nxt = PH_TX_HI;
          sclk_nxt  = 1'b1;
        end
        PH_TX_HI: begin
          sclk_nxt = 1'b0;
          if (bit_cnt_r != 3'd7) begin
            bit_cnt_nxt = bit_cnt_r + 3'd1;
            shift_nxt   = shift_r >> 1;
            phase_nxt   = PH_TX_LO;
          end else if (op_r == twrtc_pkg::CMD_WRITE && byte_cnt_r == 3'd0) begin
            bit_cnt_nxt  = 3'd0;
            byte_cnt_nxt = 3'd1;
            shift_nxt    = pend_r;
            phase_nxt    = PH_TX_LO;
          end else if (op_r == twrtc_pkg::CMD_WRITE) begin
            drv_nxt   = 1'b0;
            phase_nxt = PH_END;
          end else begin
            bit_cnt_nxt  = 3'd0;
            byte_cnt_nxt = 3'd0;
            shift_nxt    = 8'd0;
            drv_nxt      = 1'b0;
            phase_nxt    = PH_RX_LO;
          end
        end
        PH_RX_LO: begin
          shift_nxt = rx_byte;
          if (bit_cnt_r == 3'd7) begin
            vld = 1'b1;
            val = twrtc_pkg::from_bcd(rx_byte);
            idx = byte_cnt_r;
            if (rx_last) begin
              phase_nxt = PH_END;
            end else begin
              sclk_nxt     = 1'b1;
              phase_nxt    = PH_RX_HI;
              byte_cnt_nxt = byte_cnt_r + 3'd1;
              bit_cnt_nxt  = 3'd0;
              shift_nxt    = 8'd0;
            end
          end else begin
            bit_cnt_nxt = bit_cnt_r + 3'd1;
            sclk_nxt    = 1'b1;
            phase_nxt   = PH_RX_HI;
          end
        end
        PH_RX_HI: begin
          sclk_nxt  = 1'b0;
          phase_nxt = PH_RX_LO;
        end
        default: begin
          ce_nxt    = 1'b0;
          sclk_nxt  = 1'b0;
          drv_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.chip_enable  = ce_nxt;
    res.serial_clock = sclk_nxt;
    res.dat_out      = drv_nxt & shift_nxt[0];
    res.dat_drive    = drv_nxt;
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.value_valid  = vld;
    res.value        = val;
    res.value_index  = idx;
    res.value_last   = vld & rx_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      op_r       <= 2'd0;
      bit_cnt_r  <= 3'd0;
      byte_cnt_r <= 3'd0;
      shift_r    <= 8'd0;
      pend_r     <= 8'd0;
      div_r      <= 8'd0;
      ce_r       <= 1'b0;
      sclk_r     <= 1'b0;
      drv_r      <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      op_r       <= op_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      shift_r    <= shift_nxt;
      pend_r     <= pend_nxt;
      div_r      <= div_nxt;
      ce_r       <= ce_nxt;
      sclk_r     <= sclk_nxt;
      drv_r      <= drv_nxt;
    end
  end

  a_idle_pins_low: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (!ce_r && !sclk_r && !drv_r))
    else $error("pins active while idle");

  a_drive_needs_ce: assert property (@(posedge clk) disable iff (!rst_n)
    drv_r |-> ce_r)
    else $error("data driven without chip enable");

  a_byte_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r < 3'(twrtc_pkg::BURST_BYTES))
    else $error("byte count out of range");

  a_rx_released: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RX_LO || phase_r == PH_RX_HI) |-> !drv_r)
    else $error("data pin driven during receive");

endmodule

// ----- hdl/three_wire_rtc_serial_master.sv -----
// Three-wire RTC serial master. Each request is one clock tick of the link
// sequencer: it carries the command (none, write, single read, burst read),
// the command byte, the decimal write value and the sampled data pin level,
// and yields exactly one result with the pin levels after that tick plus any
// completed read byte in decimal. One request is taken every clock cycle; its
// result appears in the output register on the next cycle. While a result
// waits for out_ch.ready the input stalls, so sustained rate is one request
// per cycle with the consumer ready. cfg_wdata sets ticks per half period of
// the serial clock (0 counts as 1); write it only while no transfer runs.
module three_wire_rtc_serial_master (
  input  logic              clk,
  input  logic              rst_n,
  twrtc_in_if.sink          in_ch,
  twrtc_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);

  logic [7:0]      half_period_r;
  logic            out_valid_r;
  twrtc_pkg::res_t out_r;
  twrtc_pkg::req_t req;
  twrtc_pkg::res_t res;
  logic            accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign req.cmd         = in_ch.cmd;
  assign req.reg_addr    = in_ch.reg_addr;
  assign req.write_value = in_ch.write_value;
  assign req.dat_in      = in_ch.dat_in;

  twrtc_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (accept),
    .req         (req),
    .half_period (half_period_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= 8'd1;
    end else if (cfg_we) begin
      half_period_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.chip_enable  = out_r.chip_enable;
  assign out_ch.serial_clock = out_r.serial_clock;
  assign out_ch.dat_out      = out_r.dat_out;
  assign out_ch.dat_drive    = out_r.dat_drive;
  assign out_ch.busy_res     = out_r.busy_res;
  assign out_ch.value_valid  = out_r.value_valid;
  assign out_ch.value        = out_r.value;
  assign out_ch.value_index  = out_r.value_index;
  assign out_ch.value_last   = out_r.value_last;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");

  a_value_in_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.value_valid) |-> (out_r.chip_enable && !out_r.dat_drive))
    else $error("read byte outside receive");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.busy_res) |-> (!out_r.chip_enable && !out_r.serial_clock))
    else $error("pins active while not busy");

endmodule
